// ----- hw/rtl/mlk_pkg.sv -----
// ============================================================================
// mlk_pkg
// Shared types, codes and the Morse table for the LED keyer.
// ============================================================================
package mlk_pkg;

    // longest code in the table
    localparam int MAX_ELEMENTS = 5;

    // command codes on the input channel
    typedef enum logic [1:0] {
        CMD_CHAR = 2'd0,
        CMD_TICK = 2'd1,
        CMD_END  = 2'd2
    } t_cmd;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_DOT  = 2'd0,
        CFG_DASH = 2'd1,
        CFG_GAP  = 2'd2
    } t_cfg_reg;

    // player phases
    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_LIT   = 2'd1,
        PH_GAP   = 2'd2,
        PH_FINAL = 2'd3
    } t_phase;

    // one table entry: bit i set means element i is a dash
    typedef struct packed {
        logic [MAX_ELEMENTS-1:0] bits;
        logic [2:0]              count;
    } t_morse;

    // lookup result handed to the player
    typedef struct packed {
        logic   known;
        t_morse code;
    } t_lookup;

    // a zero register acts as one
    function automatic logic [15:0] at_least_one(input logic [15:0] v);
        return (v == 16'd0) ? 16'd1 : v;
    endfunction

    // table: A-Z at 0..25, digits 0-9 at 26..35
    function automatic t_morse morse_entry(input logic [5:0] idx);
        t_morse e;
        e = '0;
        case (idx)
            6'd0:  e = '{5'd2,  3'd2};
            6'd1:  e = '{5'd1,  3'd4};
            6'd2:  e = '{5'd5,  3'd4};
            6'd3:  e = '{5'd1,  3'd3};
            6'd4:  e = '{5'd0,  3'd1};
            6'd5:  e = '{5'd4,  3'd4};
            6'd6:  e = '{5'd3,  3'd3};
            6'd7:  e = '{5'd0,  3'd4};
            6'd8:  e = '{5'd0,  3'd2};
            6'd9:  e = '{5'd14, 3'd4};
            6'd10: e = '{5'd5,  3'd3};
            6'd11: e = '{5'd2,  3'd4};
            6'd12: e = '{5'd3,  3'd2};
            6'd13: e = '{5'd1,  3'd2};
            6'd14: e = '{5'd7,  3'd3};
            6'd15: e = '{5'd6,  3'd4};
            6'd16: e = '{5'd11, 3'd4};
            6'd17: e = '{5'd2,  3'd3};
            6'd18: e = '{5'd0,  3'd3};
            6'd19: e = '{5'd1,  3'd1};
            6'd20: e = '{5'd4,  3'd3};
            6'd21: e = '{5'd8,  3'd4};
            6'd22: e = '{5'd6,  3'd3};
            6'd23: e = '{5'd9,  3'd4};
            6'd24: e = '{5'd13, 3'd4};
            6'd25: e = '{5'd3,  3'd4};
            6'd26: e = '{5'd31, 3'd5};
            6'd27: e = '{5'd30, 3'd5};
            6'd28: e = '{5'd28, 3'd5};
            6'd29: e = '{5'd24, 3'd5};
            6'd30: e = '{5'd16, 3'd5};
            6'd31: e = '{5'd0,  3'd5};
            6'd32: e = '{5'd1,  3'd5};
            6'd33: e = '{5'd3,  3'd5};
            6'd34: e = '{5'd7,  3'd5};
            6'd35: e = '{5'd15, 3'd5};
            default: e = '0;
        endcase
        return e;
    endfunction

endpackage

// ----- hw/rtl/mlk_lookup.sv -----
// ============================================================================
// mlk_lookup
// Maps an ASCII code to its Morse pattern and element count.
// ============================================================================
module mlk_lookup
    import mlk_pkg::*;
(
    input  logic [7:0] i_char_code,
    output t_lookup    o_lookup
);

    logic       w_upper;
    logic       w_digit;
    logic [7:0] w_upper_off;
    logic [7:0] w_digit_off;
    logic [5:0] w_idx;

    // classify the character
    assign w_upper     = (i_char_code >= 8'h41) && (i_char_code <= 8'h5A);
    assign w_digit     = (i_char_code >= 8'h30) && (i_char_code <= 8'h39);
    assign w_upper_off = i_char_code - 8'h41;
    assign w_digit_off = i_char_code - 8'h30 + 8'd26;

    // table index
    always_comb begin
        if (w_upper) begin
            w_idx = w_upper_off[5:0];
        end else begin
            w_idx = w_digit_off[5:0];
        end
    end

    // table read, masked off for unknown codes
    always_comb begin
        o_lookup.known = w_upper || w_digit;
        if (w_upper || w_digit) begin
            o_lookup.code = morse_entry(w_idx);
        end else begin
            o_lookup.code = '0;
        end
    end

endmodule

// ----- hw/rtl/morse_led_keyer.sv -----
// ============================================================================
// morse_led_keyer
// Morse keyer that plays characters on an active-low LED pin, timed by ticks.
// ============================================================================
// The block takes one command per clock cycle while o_ready is high
// (character, tick or end of message) and returns one registered result per
// command, in the cycle after the transfer at the earliest. All state
// advances on the transfer itself: the table lookup and the phase/tick
// counter update sit between the player registers and the result register.
// A result register plus a one-entry skid stage part the two channels, so
// input ready drops only when both hold undelivered results. Configuration
// writes are always ready and take effect at the next phase load.
module morse_led_keyer
    import mlk_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_cmd,
    input  logic [7:0]  i_char_code,
    // result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_led_level,
    output logic        o_busy_res,
    output logic        o_accepted,
    output logic        o_known_char,
    // configuration channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    typedef struct packed {
        logic led_level;
        logic busy_res;
        logic accepted;
        logic known_char;
    } t_result;

    // configuration registers
    logic [15:0] r_dot_ticks;
    logic [15:0] r_dash_ticks;
    logic [15:0] r_gap_ticks;

    // player state
    t_phase                  r_phase,   n_phase;
    logic [MAX_ELEMENTS-1:0] r_pattern, n_pattern;
    logic [2:0]              r_count,   n_count;
    logic [2:0]              r_index,   n_index;
    logic [15:0]             r_tick,    n_tick;
    logic                    r_pin,     n_pin;

    // result register and skid stage
    t_result r_out,  n_out;
    logic    r_out_valid, n_out_valid;
    t_result r_skid, n_skid;
    logic    r_skid_valid, n_skid_valid;

    t_lookup                 w_lookup;
    t_result                 w_result;
    logic                    w_in_fire;
    logic                    w_out_fire;
    logic                    w_busy;
    logic [15:0]             w_tick_dec;
    logic                    w_tick_done;
    logic [2:0]              w_next_index;
    logic                    w_more;
    logic [MAX_ELEMENTS-1:0] w_next_shift;
    logic                    w_next_dash;
    logic                    w_accepted;
    logic                    w_known;

    // character lookup
    mlk_lookup u_lookup (
        .i_char_code (i_char_code),
        .o_lookup    (w_lookup)
    );

    // handshakes
    assign o_ready     = !r_skid_valid;
    assign o_cfg_ready = 1'b1;
    assign w_in_fire   = i_valid && o_ready;
    assign w_out_fire  = r_out_valid && i_ready;

    // tick and element bookkeeping
    assign w_busy       = (r_phase != PH_IDLE);
    assign w_tick_dec   = r_tick - 16'd1;
    assign w_tick_done  = (w_tick_dec == 16'd0);
    assign w_next_index = r_index + 3'd1;
    assign w_more       = ({1'b0, r_index} + 4'd1) < {1'b0, r_count};
    assign w_next_shift = r_pattern >> w_next_index;
    assign w_next_dash  = w_next_shift[0];

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (w_in_fire) begin
            case (t_cmd'(i_cmd))
                CMD_CHAR: begin
                    if (!w_busy && w_lookup.known && (w_lookup.code.count != 3'd0)) begin
                        n_phase = PH_LIT;
                    end
                end
                CMD_TICK: begin
                    if (w_busy && w_tick_done) begin
                        unique case (r_phase)
                            PH_LIT:   n_phase = PH_GAP;
                            PH_GAP:   n_phase = w_more ? PH_LIT : PH_IDLE;
                            PH_FINAL: n_phase = PH_IDLE;
                            default:  n_phase = r_phase;
                        endcase
                    end
                end
                CMD_END: begin
                    if (!w_busy) begin
                        n_phase = PH_FINAL;
                    end
                end
                default: n_phase = r_phase;
            endcase
        end
    end

    // player datapath and result fields
    always_comb begin
        n_pattern  = r_pattern;
        n_count    = r_count;
        n_index    = r_index;
        n_tick     = r_tick;
        n_pin      = r_pin;
        w_accepted = 1'b0;
        w_known    = 1'b0;
        if (w_in_fire) begin
            case (t_cmd'(i_cmd))
                CMD_CHAR: begin
                    w_known = w_lookup.known;
                    if (!w_busy) begin
                        w_accepted = 1'b1;
                        if (w_lookup.known && (w_lookup.code.count != 3'd0)) begin
                            n_pattern = w_lookup.code.bits;
                            n_count   = w_lookup.code.count;
                            n_index   = 3'd0;
                            n_pin     = 1'b0;
                            n_tick    = at_least_one(w_lookup.code.bits[0] ?
                                                     r_dash_ticks : r_dot_ticks);
                        end
                    end
                end
                CMD_TICK: begin
                    if (w_busy) begin
                        n_tick = w_tick_dec;
                        if (w_tick_done) begin
                            if (r_phase == PH_LIT) begin
                                n_pin  = 1'b1;
                                n_tick = at_least_one(r_gap_ticks);
                            end else if (r_phase == PH_GAP && w_more) begin
                                n_index = w_next_index;
                                n_pin   = 1'b0;
                                n_tick  = at_least_one(w_next_dash ?
                                                       r_dash_ticks : r_dot_ticks);
                            end else begin
                                n_pin = 1'b1;
                            end
                        end
                    end
                end
                CMD_END: begin
                    if (!w_busy) begin
                        w_accepted = 1'b1;
                        n_pin      = 1'b1;
                        n_tick     = at_least_one(r_gap_ticks);
                    end
                end
                default: begin
                    w_accepted = 1'b0;
                end
            endcase
        end
    end

    // result of this transfer
    always_comb begin
        w_result.led_level  = n_pin;
        w_result.busy_res   = (n_phase != PH_IDLE);
        w_result.accepted   = w_accepted;
        w_result.known_char = w_known;
    end

    // result register and skid stage
    always_comb begin
        n_out        = r_out;
        n_out_valid  = r_out_valid;
        n_skid       = r_skid;
        n_skid_valid = r_skid_valid;
        if (w_out_fire) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end else begin
                n_out       = w_result;
                n_out_valid = w_in_fire;
            end
        end else if (w_in_fire) begin
            if (!r_out_valid) begin
                n_out       = w_result;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = w_result;
                n_skid_valid = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot_ticks  <= 16'd250;
            r_dash_ticks <= 16'd1000;
            r_gap_ticks  <= 16'd1000;
            r_phase      <= PH_IDLE;
            r_pattern    <= '0;
            r_count      <= 3'd0;
            r_index      <= 3'd0;
            r_tick       <= 16'd0;
            r_pin        <= 1'b1;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (t_cfg_reg'(i_cfg_index))
                    CFG_DOT:  r_dot_ticks  <= i_cfg_data;
                    CFG_DASH: r_dash_ticks <= i_cfg_data;
                    CFG_GAP:  r_gap_ticks  <= i_cfg_data;
                    default:  r_dot_ticks  <= r_dot_ticks;
                endcase
            end
            r_phase      <= n_phase;
            r_pattern    <= n_pattern;
            r_count      <= n_count;
            r_index      <= n_index;
            r_tick       <= n_tick;
            r_pin        <= n_pin;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    // result payload, no reset
    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    // outputs
    assign o_valid      = r_out_valid;
    assign o_led_level  = r_out.led_level;
    assign o_busy_res   = r_out.busy_res;
    assign o_accepted   = r_out.accepted;
    assign o_known_char = r_out.known_char;

    // skid stage only fills behind a held result
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid stage full while result register empty");

    // pin is lit exactly in the lit phase
    a_pin_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pin == 1'b0) == (r_phase == PH_LIT))
        else $error("pin level disagrees with phase");

    // a running phase always has ticks left
    a_tick_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_IDLE) |-> (r_tick != 16'd0))
        else $error("busy with zero ticks left");

    // element index stays inside the character
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_LIT || r_phase == PH_GAP) |-> (r_index < r_count))
        else $error("element index beyond element count");

    // ticks while idle change nothing
    a_idle_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && i_cmd == CMD_TICK && r_phase == PH_IDLE)
        |=> (r_phase == PH_IDLE && r_pin == 1'b1))
        else $error("idle tick started playback");

endmodule

// ----- bench/morse_led_keyer_test.sv -----
`timescale 1ns / 1ps
// ============================================================================
// morse_led_keyer_test
// Self-checking bench for the Morse LED keyer. Commands go in over the
// command channel and register values over the config channel. A local
// model of the keyer predicts the pin level, busy, accepted and known flags
// for every command. Each result is checked against the oldest prediction.
// Directed tests cover reset timing, table edges, rejects, a zero register,
// retiming while a character plays and long register values. Random
// messages with back-pressure on both sides follow.
// ============================================================================
module morse_led_keyer_test;
    import mlk_pkg::*;

    localparam logic [1:0] CMD_UNUSED    = 2'd3;
    localparam int         IDLE_PCT      = 32;
    localparam int         HOLD_CYCLES   = 300;
    localparam int         STALL_LIMIT   = 5000;
    localparam int         RANDOM_ITEMS  = 300;
    localparam int         SETTLE_CYCLES = 10;

    typedef struct packed {
        logic led_level;
        logic busy;
        logic accepted;
        logic known;
    } t_pin_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_cmd;
    logic [7:0]  i_char_code;
    logic        o_valid;
    logic        i_ready;
    logic        o_led_level;
    logic        o_busy_res;
    logic        o_accepted;
    logic        o_known_char;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    // keyer model: timing registers and player state
    logic [15:0]             dot_len;
    logic [15:0]             dash_len;
    logic [15:0]             gap_len;
    logic [MAX_ELEMENTS-1:0] key_pattern;
    logic [2:0]              key_count;
    logic [2:0]              key_index;
    t_phase                  key_phase;
    logic [15:0]             key_ticks_left;
    logic                    key_pin;

    t_pin_result pending_pin_results[$];
    int          fail_count;
    bit          calm;
    bit          hold_results;

    morse_led_keyer u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_cmd        (i_cmd),
        .i_char_code  (i_char_code),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_led_level  (o_led_level),
        .o_busy_res   (o_busy_res),
        .o_accepted   (o_accepted),
        .o_known_char (o_known_char),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    // 100 MHz clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // dots and dashes of each letter and digit, empty when not in the table
    function automatic string morse_spelling(input logic [7:0] code);
        string s;
        s = "";
        case (code)
            "A": s = ".-";    "B": s = "-...";  "C": s = "-.-.";  "D": s = "-..";
            "E": s = ".";     "F": s = "..-.";  "G": s = "--.";   "H": s = "....";
            "I": s = "..";    "J": s = ".---";  "K": s = "-.-";   "L": s = ".-..";
            "M": s = "--";    "N": s = "-.";    "O": s = "---";   "P": s = ".--.";
            "Q": s = "--.-";  "R": s = ".-.";   "S": s = "...";   "T": s = "-";
            "U": s = "..-";   "V": s = "...-";  "W": s = ".--";   "X": s = "-..-";
            "Y": s = "-.--";  "Z": s = "--..";
            "0": s = "-----"; "1": s = ".----"; "2": s = "..---"; "3": s = "...--";
            "4": s = "....-"; "5": s = "....."; "6": s = "-...."; "7": s = "--...";
            "8": s = "---.."; "9": s = "----.";
            default: s = "";
        endcase
        return s;
    endfunction

    // a zero register counts as a single tick
    function automatic logic [15:0] ticks_or_one(input logic [15:0] v);
        return (v == 16'd0) ? 16'd1 : v;
    endfunction

    function automatic void reset_keyer_model();
        dot_len        = 16'd250;
        dash_len       = 16'd1000;
        gap_len        = 16'd1000;
        key_pattern    = '0;
        key_count      = '0;
        key_index      = '0;
        key_phase      = PH_IDLE;
        key_ticks_left = '0;
        key_pin        = 1'b1;
    endfunction

    // light the LED for the current element
    function automatic void light_element();
        key_pin        = 1'b0;
        key_phase      = PH_LIT;
        key_ticks_left = ticks_or_one(key_pattern[key_index] ? dash_len : dot_len);
    endfunction

    // advance the model by one command and return the expected result
    function automatic t_pin_result keyer_predict(input logic [1:0] cmd,
                                                  input logic [7:0] code);
        string                   spelling;
        logic                    was_busy;
        logic [MAX_ELEMENTS-1:0] dashes;
        int                      n;
        t_pin_result             r;
        r        = '0;
        was_busy = (key_phase != PH_IDLE);
        if (cmd == CMD_CHAR) begin
            spelling = morse_spelling(code);
            r.known  = (spelling.len() != 0);
            if (!was_busy) begin
                r.accepted = 1'b1;
                if (r.known) begin
                    dashes = '0;
                    n      = 0;
                    while (n < spelling.len() && n < MAX_ELEMENTS) begin
                        if (spelling[n] == "-") begin
                            dashes[n] = 1'b1;
                        end
                        n++;
                    end
                    key_pattern = dashes;
                    key_count   = n[2:0];
                    key_index   = '0;
                    light_element();
                end
            end
        end else if (cmd == CMD_TICK) begin
            if (was_busy) begin
                key_ticks_left = key_ticks_left - 16'd1;
                if (key_ticks_left == 16'd0) begin
                    if (key_phase == PH_LIT) begin
                        key_pin        = 1'b1;
                        key_phase      = PH_GAP;
                        key_ticks_left = ticks_or_one(gap_len);
                    end else if (key_phase == PH_GAP &&
                                 int'(key_index) + 1 < int'(key_count)) begin
                        key_index = key_index + 3'd1;
                        light_element();
                    end else begin
                        key_phase = PH_IDLE;
                        key_pin   = 1'b1;
                    end
                end
            end
        end else if (cmd == CMD_END) begin
            if (!was_busy) begin
                r.accepted     = 1'b1;
                key_phase      = PH_FINAL;
                key_pin        = 1'b1;
                key_ticks_left = ticks_or_one(gap_len);
            end
        end
        r.led_level = key_pin;
        r.busy      = (key_phase != PH_IDLE);
        return r;
    endfunction

    // one command transfer, with random idle cycles ahead of it
    task automatic send_item(input logic [1:0] cmd, input logic [7:0] code);
        @(negedge i_clk);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_cmd       <= cmd;
        i_char_code <= code;
        do @(posedge i_clk); while (!o_ready);
        pending_pin_results.push_back(keyer_predict(cmd, code));
    endtask

    // stop offering commands and wait for every result to come back
    task automatic drain_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_pin_results.size() != 0) @(posedge i_clk);
    endtask

    // register write, only once the result channel is empty
    task automatic write_register(input t_cfg_reg idx, input logic [15:0] value);
        drain_results();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_DOT:  dot_len  = value;
            CFG_DASH: dash_len = value;
            CFG_GAP:  gap_len  = value;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic tick_until_idle();
        while (key_phase != PH_IDLE) begin
            send_item(CMD_TICK, 8'($urandom_range(0, 255)));
        end
    endtask

    // mostly short lengths, some zeros and a few longer ones
    function automatic logic [15:0] pick_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            return 16'd0;
        end else if (pick < 90) begin
            return 16'($urandom_range(1, 6));
        end
        return 16'($urandom_range(7, 40));
    endfunction

    // reset register values: one dot character at full length
    task automatic test_reset_timing();
        send_item(CMD_CHAR, "E");
        tick_until_idle();
    endtask

    // idle ticks, unused command, end handling, table edges and rejects
    task automatic test_directed_commands();
        string played;
        string unknown;
        int    i;
        played  = "Z095Q";
        unknown = "a@[/:`{";
        write_register(CFG_DOT, 16'd1);
        write_register(CFG_DASH, 16'd2);
        write_register(CFG_GAP, 16'd1);
        send_item(CMD_TICK, 8'h00);
        send_item(CMD_UNUSED, 8'hFF);
        // end of message, then a second end while the gap runs
        send_item(CMD_END, 8'hA5);
        send_item(CMD_END, 8'h5A);
        tick_until_idle();
        // character and end while a character plays
        send_item(CMD_CHAR, "A");
        send_item(CMD_CHAR, "B");
        send_item(CMD_CHAR, "@");
        send_item(CMD_END, 8'h00);
        tick_until_idle();
        for (i = 0; i < played.len(); i++) begin
            send_item(CMD_CHAR, played[i]);
            tick_until_idle();
        end
        // characters outside the table play nothing
        for (i = 0; i < unknown.len(); i++) begin
            send_item(CMD_CHAR, unknown[i]);
        end
        send_item(CMD_CHAR, 8'h00);
        send_item(CMD_CHAR, 8'hFF);
    endtask

    // a zero register acts as one tick
    task automatic test_zero_register();
        write_register(CFG_DOT, 16'd0);
        write_register(CFG_GAP, 16'd0);
        send_item(CMD_CHAR, "S");
        tick_until_idle();
        write_register(CFG_DOT, 16'd1);
        write_register(CFG_GAP, 16'd1);
    endtask

    // new lengths land at the next phase load, not on the running count
    task automatic test_retime_while_playing();
        write_register(CFG_DASH, 16'd4);
        send_item(CMD_CHAR, "T");
        send_item(CMD_TICK, 8'h11);
        write_register(CFG_DASH, 16'd1);
        write_register(CFG_GAP, 16'd3);
        tick_until_idle();
        send_item(CMD_CHAR, "T");
        tick_until_idle();
    endtask

    // long lengths, no idling on either side
    task automatic test_longest_lengths();
        calm = 1'b1;
        write_register(CFG_DOT, 16'd60);
        write_register(CFG_DASH, 16'd120);
        write_register(CFG_GAP, 16'd30);
        send_item(CMD_CHAR, "A");
        tick_until_idle();
        write_register(CFG_DOT, 16'd1);
        write_register(CFG_DASH, 16'd1);
        write_register(CFG_GAP, 16'd1);
        send_item(CMD_CHAR, "0");
        tick_until_idle();
        calm = 1'b0;
    endtask

    // receiver holds off so the keyer fills and stalls its input
    task automatic test_result_backpressure();
        int i;
        write_register(CFG_DOT, 16'd3);
        write_register(CFG_DASH, 16'd5);
        write_register(CFG_GAP, 16'd2);
        drain_results();
        hold_results = 1'b1;
        send_item(CMD_CHAR, "K");
        for (i = 0; i < 20; i++) begin
            send_item(CMD_TICK, 8'($urandom_range(0, 255)));
        end
        // sender waits for every outstanding result
        drain_results();
        send_item(CMD_CHAR, "N");
        tick_until_idle();
    endtask

    // random messages with occasional retiming, rejects and noise
    task automatic test_random_messages();
        string      alphabet;
        int         sent;
        int         next_retune;
        int         pick;
        logic [1:0] cmd;
        logic [7:0] code;
        alphabet    = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789";
        sent        = 0;
        next_retune = 0;
        while (sent < RANDOM_ITEMS) begin
            if (sent >= next_retune) begin
                write_register(CFG_DOT, pick_length());
                write_register(CFG_DASH, pick_length());
                write_register(CFG_GAP, pick_length());
                next_retune = sent + $urandom_range(100, 250);
            end
            pick = $urandom_range(0, 99);
            code = 8'($urandom_range(0, 255));
            if (key_phase == PH_IDLE) begin
                if (pick < 70) begin
                    cmd = CMD_CHAR;
                    if ($urandom_range(0, 3) != 0) begin
                        code = alphabet[$urandom_range(0, 35)];
                    end
                end else if (pick < 85) begin
                    cmd = CMD_END;
                end else if (pick < 95) begin
                    cmd = CMD_TICK;
                end else begin
                    cmd = CMD_UNUSED;
                end
            end else begin
                if (pick < 84) begin
                    cmd = CMD_TICK;
                end else if (pick < 90) begin
                    cmd = CMD_CHAR;
                end else if (pick < 95) begin
                    cmd = CMD_END;
                end else begin
                    cmd = CMD_UNUSED;
                end
            end
            send_item(cmd, code);
            if (cmd != CMD_UNUSED) begin
                sent++;
            end
        end
    endtask

    // result receiver: random stalls, or a long hold-off on request
    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_results) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_results = 1'b0;
                i_ready <= 1'b1;
            end else if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    task automatic compare_field(input string field, input logic want, input logic got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0b, actual %0b", $time, field, want, got);
            fail_count++;
        end
    endtask

    // compare each result transfer with the oldest prediction
    always @(posedge i_clk) begin : result_checker
        t_pin_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_pin_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual led %0b busy %0b",
                         $time, o_led_level, o_busy_res);
                fail_count++;
            end else begin
                want = pending_pin_results.pop_front();
                compare_field("led_level", want.led_level, o_led_level);
                compare_field("busy_res", want.busy, o_busy_res);
                compare_field("accepted", want.accepted, o_accepted);
                compare_field("known_char", want.known, o_known_char);
            end
        end
    end

    // watchdog on cycles with no transfer on any channel
    initial begin : transfer_watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("%0t: watchdog, no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("tb: failure");
        $finish;
    end

    // test sequence
    initial begin
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_cmd        = CMD_TICK;
        i_char_code  = 8'h00;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = CFG_DOT;
        i_cfg_data   = 16'h0000;
        fail_count   = 0;
        calm         = 1'b0;
        hold_results = 1'b0;
        reset_keyer_model();
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_timing();
        test_directed_commands();
        test_zero_register();
        test_retime_while_playing();
        test_longest_lengths();
        test_result_backpressure();
        test_random_messages();

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_pin_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
